@@ hdl/lned_pkg.sv @@
// lned_pkg: types, codes and constants of the line editor with echo
// no dependencies; every other file of the block but lned_ram imports it
`default_nettype none

package lned_pkg;

    localparam int LINE_STORE_DEPTH = 64;
    localparam int AW               = $clog2(LINE_STORE_DEPTH);
    localparam int SZ_W             = 7;
    localparam int LEN_W            = 6;
    localparam int CFG_W            = 6;
    localparam int Q_DEPTH          = 4;
    localparam int Q_AW             = $clog2(Q_DEPTH);

    localparam logic [CFG_W-1:0] MAX_LINE_SIZE_RST = CFG_W'(63);

    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_NL    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_ECHO = 2'd1;
    localparam logic [1:0] OP_BS   = 2'd2;

    typedef struct packed {
        logic [1:0]    op;
        logic [7:0]    key;
        logic          endl;
        logic [AW-1:0] len;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/lned_if.sv @@
// lned_if: valid/ready channel interfaces for keys, results and configuration
// depends on lned_pkg
`default_nettype none

interface lned_key_if
    import lned_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink   (input valid, input key_byte, output ready);
endinterface

interface lned_res_if
    import lned_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;

    modport source (output valid, output kind, output out_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input line_length,
                    input last, output ready);
endinterface

interface lned_cfg_if
    import lned_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_line_size;

    modport source (output valid, output max_line_size, input ready);
    modport sink   (input valid, input max_line_size, output ready);
endinterface

`default_nettype wire

@@ hdl/line_editor_with_echo_core.sv @@
// line_editor_with_echo_core: top level of the line editor with echo
// depends on lned_pkg, lned_if, lned_ram, lned_front, lned_queue, lned_back
//
//   channel | dir | payload                              | word accepted when
//   key     | in  | key_byte[7:0]                        | key.valid && key.ready
//   res     | out | kind[1:0] out_byte[7:0] line_length  | res.valid && res.ready
//           |     | [5:0] last                           |
//   cfg     | in  | max_line_size[5:0]                   | cfg.valid && cfg.ready
//
// a key word is taken when key.ready is high; a plain echo or erase queues up to three words
// emitting a line reads each stored character through the registered read of the line
// store (states S_LRD then S_LWT); no key is taken while a line is emitted
// the four-entry command queue lets the front keep taking keys while a word waits on res
// rst_n clears count, sets max line size to 63, clears queue and result valid; the store is not cleared
`default_nettype none

module line_editor_with_echo_core
    import lned_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lned_key_if.sink  key,
    lned_res_if.source res,
    lned_cfg_if.sink  cfg
);

    cmd_t          push_cmd, pop_cmd;
    logic          push, pop, q_full, q_empty, line_done;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_wdata, st_rdata;

    lned_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .cfg       (cfg),
        .q_full    (q_full),
        .line_done (line_done),
        .push      (push),
        .push_cmd  (push_cmd),
        .st_we     (st_we),
        .st_waddr  (st_waddr),
        .st_wdata  (st_wdata)
    );

    lned_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    lned_ram #(
        .WIDTH (8),
        .DEPTH (LINE_STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    lned_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .st_raddr  (st_raddr),
        .st_rdata  (st_rdata),
        .line_done (line_done),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ hdl/lned_ram.sv @@
// lned_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module lned_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/lned_front.sv @@
// lned_front: accepts key words, keeps the count and limit, writes the line store
// depends on lned_pkg and lned_if; pushes commands into lned_queue
`default_nettype none

module lned_front
    import lned_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    lned_key_if.sink             key,
    lned_cfg_if.sink             cfg,
    input  wire logic            q_full,
    input  wire logic            line_done,
    output logic                 push,
    output cmd_t                 push_cmd,
    output logic                 st_we,
    output logic [AW-1:0]        st_waddr,
    output logic [7:0]           st_wdata
);

    logic [CFG_W-1:0] mls_reg;
    logic [AW-1:0]    count_reg, count_next;
    logic             pend_reg, pend_next;
    logic [SZ_W-1:0]  size, limit, cnt_ext, cnt_new_ext;
    logic             accept;
    logic             printable, erase, newline;
    logic [1:0]       op;
    logic             endl;
    logic [AW-1:0]    cnt_new;

    assign cfg.ready = 1'b1;
    assign key.ready = !q_full && !pend_reg;
    assign accept    = key.valid && key.ready;

    always_comb
    begin
        size = SZ_W'(mls_reg);
        if (size > SZ_W'(LINE_STORE_DEPTH))
        begin
            size = SZ_W'(LINE_STORE_DEPTH);
        end
        if (size < SZ_W'(2))
        begin
            size = SZ_W'(2);
        end
        limit = size - SZ_W'(1);
    end

    assign printable = key.key_byte inside {[PRINT_LO:PRINT_HI]};
    assign erase     = key.key_byte inside {BYTE_BS, BYTE_DEL};
    assign newline   = key.key_byte inside {BYTE_NL, BYTE_CR};
    assign cnt_ext   = SZ_W'(count_reg);

    always_comb
    begin
        op      = OP_NONE;
        cnt_new = count_reg;
        endl    = newline;
        st_we   = 1'b0;
        if (erase && count_reg != '0)
        begin
            op      = OP_BS;
            cnt_new = count_reg - AW'(1);
        end
        else if (printable && cnt_ext < limit)
        begin
            op      = OP_ECHO;
            cnt_new = count_reg + AW'(1);
            st_we   = accept;
        end
        cnt_new_ext = SZ_W'(cnt_new);
        if (cnt_new_ext >= limit)
        begin
            endl = 1'b1;
        end
    end

    assign st_waddr      = count_reg;
    assign st_wdata      = key.key_byte;
    assign push          = accept && (op != OP_NONE || endl);
    assign push_cmd.op   = op;
    assign push_cmd.key  = key.key_byte;
    assign push_cmd.endl = endl;
    assign push_cmd.len  = cnt_new;

    always_comb
    begin
        count_next = count_reg;
        pend_next  = pend_reg;
        if (line_done)
        begin
            pend_next = 1'b0;
        end
        if (accept)
        begin
            count_next = endl ? '0 : cnt_new;
            if (endl)
            begin
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mls_reg   <= MAX_LINE_SIZE_RST;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                mls_reg <= cfg.max_line_size;
            end
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lned_queue.sv @@
// lned_queue: short command fifo between front and back
// depends on lned_pkg
`default_nettype none

module lned_queue
    import lned_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      full,
    output logic      empty
);

    cmd_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, rd_reg;
    logic [Q_AW:0]   cnt_reg, cnt_next;

    assign full    = cnt_reg == (Q_AW+1)'(Q_DEPTH);
    assign empty   = cnt_reg == '0;
    assign pop_cmd = mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + (Q_AW+1)'(1);
            2'b01:   cnt_next = cnt_reg - (Q_AW+1)'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + Q_AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lned_back.sv @@
// lned_back: carries out commands, emits echo, line and end words
// depends on lned_pkg and lned_if; reads the line store through lned_ram
`default_nettype none

module lned_back
    import lned_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  cmd_t             q_cmd,
    output logic             pop,
    output logic [AW-1:0]    st_raddr,
    input  wire logic [7:0]  st_rdata,
    output logic             line_done,
    lned_res_if.source       res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ECHO = 3'd1;
    localparam logic [2:0] S_LRD  = 3'd2;
    localparam logic [2:0] S_LWT  = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]       state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [1:0]       step_reg, step_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             ov_reg, ov_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             last_reg, last_next;
    logic             slot_free, load, echo_done;

    assign slot_free       = !ov_reg || res.ready;
    assign st_raddr        = idx_reg;
    assign res.valid       = ov_reg;
    assign res.kind        = kind_reg;
    assign res.out_byte    = byte_reg;
    assign res.line_length = len_reg;
    assign res.last        = last_reg;
    assign echo_done       = cur_reg.op == OP_ECHO || step_reg == 2'd2;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        load       = 1'b0;
        pop        = 1'b0;
        line_done  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    cur_next  = q_cmd;
                    step_next = '0;
                    idx_next  = '0;
                    if (q_cmd.op != OP_NONE)
                    begin
                        state_next = S_ECHO;
                    end
                    else
                    begin
                        state_next = (q_cmd.len == '0) ? S_END : S_LRD;
                    end
                end
            end
            S_ECHO:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    kind_next = KIND_ECHO;
                    len_next  = '0;
                    last_next = echo_done && !cur_reg.endl;
                    if (cur_reg.op == OP_ECHO)
                    begin
                        byte_next = cur_reg.key;
                    end
                    else
                    begin
                        byte_next = (step_reg == 2'd1) ? BYTE_SPACE : BYTE_BS;
                    end
                    step_next = step_reg + 2'd1;
                    if (echo_done)
                    begin
                        if (!cur_reg.endl)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = (cur_reg.len == '0) ? S_END : S_LRD;
                        end
                    end
                end
            end
            S_LRD:
            begin
                state_next = S_LWT;
            end
            S_LWT:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    kind_next = KIND_CHAR;
                    byte_next = st_rdata;
                    len_next  = '0;
                    last_next = 1'b0;
                    if (idx_reg == cur_reg.len - AW'(1))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_LRD;
                    end
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    line_done  = 1'b1;
                    kind_next  = KIND_END;
                    byte_next  = '0;
                    len_next   = LEN_W'(cur_reg.len);
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (load)
        begin
            ov_next = 1'b1;
        end
        else
        begin
            ov_next = ov_reg && !res.ready;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/lned_checker.sv @@
// lned_checker: port-level assertions on the result channel of the core
// depends on lned_pkg; bound to line_editor_with_echo_core
`default_nettype none

module lned_checker
    import lned_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic [1:0]       res_kind,
    input wire logic [7:0]       res_out_byte,
    input wire logic [LEN_W-1:0] res_line_length,
    input wire logic             res_last
);

    // stalled word holds its valid, kind, byte and last flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind)
            && $stable(res_out_byte) && $stable(res_last))
        else $error("stalled result word changed");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_END |-> res_last && res_out_byte == 8'd0)
        else $error("end marker without last or with nonzero byte");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_kind == KIND_ECHO || res_kind == KIND_CHAR
            || res_kind == KIND_END)
        else $error("undefined result kind");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_END |-> res_line_length == '0)
        else $error("line length on a non-end word");

    a_char_no_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_CHAR |-> !res_last)
        else $error("line character marked last");

endmodule

bind line_editor_with_echo_core lned_checker u_lned_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_kind        (res.kind),
    .res_out_byte    (res.out_byte),
    .res_line_length (res.line_length),
    .res_last        (res.last)
);

`default_nettype wire
